// ----- hw/rtl/tpst_pkg.sv -----
`timescale 1ns / 1ps
// tpst_pkg: shared constants and types for the triangle point/segment test core
// used by triangle_point_segment_test_core and its checker; no dependencies
package tpst_pkg;

   // tolerance register: q0.14 epsilon
   localparam int TOL_WIDTH = 10;
   localparam int TOL_FRAC = 14;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 10'd16;

   // csr port geometry
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // csr word index (paddr bit 2)
   typedef enum logic {
      CSR_TOLERANCE = 1'b0
   } csr_reg_type;

endpackage

// ----- hw/rtl/triangle_point_segment_test_core.sv -----
`timescale 1ns / 1ps
// triangle_point_segment_test_core: pipelined point-in-triangle, barycentric and
// segment crossing test; depends on tpst_pkg
//
// One item (segment p1-p2 plus triangle a, b, c, all signed q12.4) enters per
// clock and one result leaves per clock while rsp_ready holds high. An item
// passes BARY_FRAC_BITS + 12 register stages: seven stages of cross products,
// split wide multiplies and range compares, then a restoring divider that
// produces one quotient bit per stage for the three barycentrics in parallel
// (one saturation stage plus BARY_FRAC_BITS + 3 bit stages), then the output
// register. Every stage has its own valid bit and holds only while the stage
// after it is full and stalled, so bubbles collapse and the input keeps
// taking transfers while a finished result waits on rsp_ready, as long as an
// earlier stage is empty. The crossing test is exact: products of the 35-bit
// edge functions are cut into two partial products each and summed in the
// next stage. The tolerance register (q0.14) lives at byte address 0 and is
// meant to be written only while no item is in flight.
module triangle_point_segment_test_core #(
   parameter int COORD_WIDTH    = 16,
   parameter int BARY_FRAC_BITS = 14
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // input channel
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [COORD_WIDTH-1:0]           req_point_x,
   input  logic signed [COORD_WIDTH-1:0]           req_point_y,
   input  logic signed [COORD_WIDTH-1:0]           req_prev_x,
   input  logic signed [COORD_WIDTH-1:0]           req_prev_y,
   input  logic                                    req_segment_valid,
   input  logic signed [COORD_WIDTH-1:0]           req_vertex_a_x,
   input  logic signed [COORD_WIDTH-1:0]           req_vertex_a_y,
   input  logic signed [COORD_WIDTH-1:0]           req_vertex_b_x,
   input  logic signed [COORD_WIDTH-1:0]           req_vertex_b_y,
   input  logic signed [COORD_WIDTH-1:0]           req_vertex_c_x,
   input  logic signed [COORD_WIDTH-1:0]           req_vertex_c_y,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_point_inside,
   output logic                                    rsp_segment_crosses,
   output logic signed [BARY_FRAC_BITS+3:0]        rsp_bary_a,
   output logic signed [BARY_FRAC_BITS+3:0]        rsp_bary_b,
   output logic signed [BARY_FRAC_BITS+3:0]        rsp_bary_c,
   output logic                                    rsp_degenerate,
   // configuration port
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [tpst_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [tpst_pkg::CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [tpst_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                                    csr_pready
);

   // widths
   localparam int CW   = COORD_WIDTH;
   localparam int DFW  = CW + 1;             // coordinate difference
   localparam int NW   = 2 * DFW + 1;        // edge function / determinant
   localparam int BW   = NW + 1;             // edge function difference
   localparam int H    = (NW + 1) / 2;       // low half of a split operand
   localparam int HW   = NW - H;             // high half
   localparam int PLW  = NW + H + 1;
   localparam int PHW  = NW + HW;
   localparam int EW   = 2 * NW + 1;         // cross term of edge functions
   localparam int TW   = tpst_pkg::TOL_WIDTH;
   localparam int TF   = tpst_pkg::TOL_FRAC;
   localparam int TBW  = TW + BW;            // tol * |b|
   localparam int BLW  = BW + H;
   localparam int BHW  = BW + HW;
   localparam int BDW  = BW + NW;            // |b| * |d|
   localparam int TLW  = TBW + H;
   localparam int THW  = TBW + HW;
   localparam int TBDW = TBW + NW;           // tol * |b| * |d|
   localparam int PW   = BW + TF + 2;        // parameter range compare
   localparam int CMPW = EW + TF + 2;        // barycentric range compare
   localparam int F    = BARY_FRAC_BITS;
   localparam int OW   = F + 4;
   localparam int QW   = F + 3;
   localparam int XW   = NW + F + 2;         // dividend
   localparam int DS   = F + 4;              // divider stages
   localparam int NST  = DS + 8;             // all pipeline stages

   // pair (k, j) order of the three cross terms
   localparam int PK [3] = '{0, 0, 1};
   localparam int PJ [3] = '{1, 2, 2};
   // for edge k: the two cross terms it checks and whether each is negated
   localparam int PR_A [3]  = '{0, 0, 1};
   localparam int NEG_A [3] = '{0, 1, 1};
   localparam int PR_B [3]  = '{1, 2, 2};
   localparam int NEG_B [3] = '{0, 0, 1};

   typedef struct packed {
      logic [2:0][XW-1:0] rem;
      logic [2:0][QW-1:0] quo;
      logic [2:0]         sat;
      logic [2:0]         neg;
      logic [NW-1:0]      absd;
      logic               in_tri;
      logic               hit;
      logic               deg;
   } div_stage_type;

   function automatic logic signed [NW-1:0] cross2(
      input logic signed [DFW-1:0] ux,
      input logic signed [DFW-1:0] uy,
      input logic signed [DFW-1:0] vx,
      input logic signed [DFW-1:0] vy
   );
      logic signed [2*DFW-1:0] p0;
      logic signed [2*DFW-1:0] p1;
      p0 = ux * vy;
      p1 = vx * uy;
      return NW'(p0) - NW'(p1);
   endfunction

   // ------------------------------------------------------------------
   // tolerance register
   // ------------------------------------------------------------------
   logic [TW-1:0] tol_ff;
   logic [TW-1:0] tol_in;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      tol_in = tol_ff;
      csr_prdata = '0;
      unique case (tpst_pkg::csr_reg_type'(csr_paddr[2]))
         tpst_pkg::CSR_TOLERANCE: begin
            csr_prdata = tpst_pkg::CSR_DATA_WIDTH'(tol_ff);
            if (csr_wr) begin
               tol_in = csr_pwdata[TW-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= tpst_pkg::TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   // ------------------------------------------------------------------
   // stage valids and per-stage advance: a stage loads when it is empty
   // or the stage after it loads
   // ------------------------------------------------------------------
   logic [NST-1:0] v_ff;
   logic [NST-1:0] ce;

   always_comb begin
      ce[NST-1] = !v_ff[NST-1] || rsp_ready;
      for (int i = NST - 2; i >= 0; i--) begin
         ce[i] = !v_ff[i] || ce[i+1];
      end
   end

   assign req_ready = ce[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ce[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < NST; i++) begin
            if (ce[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // s1: vertex minus endpoint differences, edge vectors from a
   // order of dp/dq: ax, ay, bx, by, cx, cy
   // ------------------------------------------------------------------
   logic signed [DFW-1:0] s1_dp_ff [6];
   logic signed [DFW-1:0] s1_dq_ff [6];
   logic signed [DFW-1:0] s1_de_ff [4];   // bax, bay, cax, cay
   logic                  s1_seg_ff;

   always_ff @(posedge clock) begin
      if (ce[0]) begin
         s1_dp_ff[0] <= DFW'(req_vertex_a_x) - DFW'(req_point_x);
         s1_dp_ff[1] <= DFW'(req_vertex_a_y) - DFW'(req_point_y);
         s1_dp_ff[2] <= DFW'(req_vertex_b_x) - DFW'(req_point_x);
         s1_dp_ff[3] <= DFW'(req_vertex_b_y) - DFW'(req_point_y);
         s1_dp_ff[4] <= DFW'(req_vertex_c_x) - DFW'(req_point_x);
         s1_dp_ff[5] <= DFW'(req_vertex_c_y) - DFW'(req_point_y);
         s1_dq_ff[0] <= DFW'(req_vertex_a_x) - DFW'(req_prev_x);
         s1_dq_ff[1] <= DFW'(req_vertex_a_y) - DFW'(req_prev_y);
         s1_dq_ff[2] <= DFW'(req_vertex_b_x) - DFW'(req_prev_x);
         s1_dq_ff[3] <= DFW'(req_vertex_b_y) - DFW'(req_prev_y);
         s1_dq_ff[4] <= DFW'(req_vertex_c_x) - DFW'(req_prev_x);
         s1_dq_ff[5] <= DFW'(req_vertex_c_y) - DFW'(req_prev_y);
         s1_de_ff[0] <= DFW'(req_vertex_b_x) - DFW'(req_vertex_a_x);
         s1_de_ff[1] <= DFW'(req_vertex_b_y) - DFW'(req_vertex_a_y);
         s1_de_ff[2] <= DFW'(req_vertex_c_x) - DFW'(req_vertex_a_x);
         s1_de_ff[3] <= DFW'(req_vertex_c_y) - DFW'(req_vertex_a_y);
         s1_seg_ff   <= req_segment_valid;
      end
   end

   // ------------------------------------------------------------------
   // s2: edge functions of both endpoints and the determinant
   // n[0] is the weight of a (edge b-c), n[1] of b, n[2] of c; the
   // inside-test cross products are the same three values for p1
   // ------------------------------------------------------------------
   logic signed [NW-1:0] s2_n1_ff [3];
   logic signed [NW-1:0] s2_n2_ff [3];
   logic signed [NW-1:0] s2_d_ff;
   logic                 s2_seg_ff;

   always_ff @(posedge clock) begin
      if (ce[1]) begin
         s2_n1_ff[0] <= cross2(s1_dp_ff[2], s1_dp_ff[3], s1_dp_ff[4], s1_dp_ff[5]);
         s2_n1_ff[1] <= cross2(s1_dp_ff[4], s1_dp_ff[5], s1_dp_ff[0], s1_dp_ff[1]);
         s2_n1_ff[2] <= cross2(s1_dp_ff[0], s1_dp_ff[1], s1_dp_ff[2], s1_dp_ff[3]);
         s2_n2_ff[0] <= cross2(s1_dq_ff[2], s1_dq_ff[3], s1_dq_ff[4], s1_dq_ff[5]);
         s2_n2_ff[1] <= cross2(s1_dq_ff[4], s1_dq_ff[5], s1_dq_ff[0], s1_dq_ff[1]);
         s2_n2_ff[2] <= cross2(s1_dq_ff[0], s1_dq_ff[1], s1_dq_ff[2], s1_dq_ff[3]);
         s2_d_ff     <= cross2(s1_de_ff[0], s1_de_ff[1], s1_de_ff[2], s1_de_ff[3]);
         s2_seg_ff   <= s1_seg_ff;
      end
   end

   // ------------------------------------------------------------------
   // s3: edge differences, sign tests, dividend setup, and the split
   // partial products of the cross terms n1[k]*n2[j] - n1[j]*n2[k]
   // ------------------------------------------------------------------
   logic signed [BW-1:0]  s3_b_in    [3];
   logic signed [PLW-1:0] s3_pl_in   [3][2];
   logic signed [PHW-1:0] s3_ph_in   [3][2];
   logic [XW-1:0]         s3_x_in    [3];
   logic [2:0]            s3_neg_in;
   logic [NW-1:0]         s3_absd_in;
   logic                  s3_inside_in;

   logic signed [BW-1:0]  s3_b_ff    [3];
   logic signed [NW-1:0]  s3_n1_ff   [3];
   logic signed [PLW-1:0] s3_pl_ff   [3][2];
   logic signed [PHW-1:0] s3_ph_ff   [3][2];
   logic [XW-1:0]         s3_x_ff    [3];
   logic [2:0]            s3_neg_ff;
   logic [NW-1:0]         s3_absd_ff;
   logic                  s3_dneg_ff;
   logic                  s3_deg_ff;
   logic                  s3_inside_ff;
   logic                  s3_seg_ff;

   always_comb begin
      logic has_neg;
      logic has_pos;
      logic [NW-1:0] absn;
      has_neg = 1'b0;
      has_pos = 1'b0;
      s3_absd_in = s2_d_ff[NW-1] ? NW'(-s2_d_ff) : NW'(s2_d_ff);
      for (int k = 0; k < 3; k++) begin
         s3_b_in[k] = BW'(s2_n1_ff[k]) - BW'(s2_n2_ff[k]);
         has_neg = has_neg || s2_n1_ff[k][NW-1];
         has_pos = has_pos || (!s2_n1_ff[k][NW-1] && (s2_n1_ff[k] != '0));
         absn = s2_n1_ff[k][NW-1] ? NW'(-s2_n1_ff[k]) : NW'(s2_n1_ff[k]);
         // round to nearest: (|n| * 2^(f+1) + |d|) / (2 |d|)
         s3_x_in[k] = (XW'(absn) << (F + 1)) + XW'(s3_absd_in);
         s3_neg_in[k] = s2_n1_ff[k][NW-1] ^ s2_d_ff[NW-1];
      end
      s3_inside_in = !(has_neg && has_pos);
      for (int pr = 0; pr < 3; pr++) begin
         s3_pl_in[pr][0] = PLW'(s2_n1_ff[PK[pr]])
                           * PLW'(signed'({1'b0, s2_n2_ff[PJ[pr]][H-1:0]}));
         s3_ph_in[pr][0] = PHW'(s2_n1_ff[PK[pr]])
                           * PHW'(signed'(s2_n2_ff[PJ[pr]][NW-1:H]));
         s3_pl_in[pr][1] = PLW'(s2_n1_ff[PJ[pr]])
                           * PLW'(signed'({1'b0, s2_n2_ff[PK[pr]][H-1:0]}));
         s3_ph_in[pr][1] = PHW'(s2_n1_ff[PJ[pr]])
                           * PHW'(signed'(s2_n2_ff[PK[pr]][NW-1:H]));
      end
   end

   always_ff @(posedge clock) begin
      if (ce[2]) begin
         s3_b_ff      <= s3_b_in;
         s3_n1_ff     <= s2_n1_ff;
         s3_pl_ff     <= s3_pl_in;
         s3_ph_ff     <= s3_ph_in;
         s3_x_ff      <= s3_x_in;
         s3_neg_ff    <= s3_neg_in;
         s3_absd_ff   <= s3_absd_in;
         s3_dneg_ff   <= s2_d_ff[NW-1];
         s3_deg_ff    <= (s2_d_ff == '0);
         s3_inside_ff <= s3_inside_in;
         s3_seg_ff    <= s2_seg_ff;
      end
   end

   // ------------------------------------------------------------------
   // s4: cross terms summed, edge parameter setup, tol*|b| and the
   // split |b|*|d| products
   // ------------------------------------------------------------------
   logic signed [EW-1:0] s4_e_in    [3];
   logic [BW-1:0]        s4_absb_in [3];
   logic signed [BW-1:0] s4_ap_in   [3];
   logic [TBW-1:0]       s4_tb_in   [3];
   logic [BLW-1:0]       s4_bdl_in  [3];
   logic [BHW-1:0]       s4_bdh_in  [3];
   logic [2:0]           s4_flip_in;
   logic [2:0]           s4_bnz_in;

   logic signed [EW-1:0] s4_e_ff    [3];
   logic [BW-1:0]        s4_absb_ff [3];
   logic signed [BW-1:0] s4_ap_ff   [3];
   logic [TBW-1:0]       s4_tb_ff   [3];
   logic [BLW-1:0]       s4_bdl_ff  [3];
   logic [BHW-1:0]       s4_bdh_ff  [3];
   logic [2:0]           s4_flip_ff;
   logic [2:0]           s4_bnz_ff;
   logic [XW-1:0]        s4_x_ff    [3];
   logic [2:0]           s4_neg_ff;
   logic [NW-1:0]        s4_absd_ff;
   logic                 s4_deg_ff;
   logic                 s4_inside_ff;
   logic                 s4_seg_ff;

   always_comb begin
      for (int pr = 0; pr < 3; pr++) begin
         s4_e_in[pr] = (EW'(s3_ph_ff[pr][0]) <<< H) + EW'(s3_pl_ff[pr][0])
                     - (EW'(s3_ph_ff[pr][1]) <<< H) - EW'(s3_pl_ff[pr][1]);
      end
      for (int k = 0; k < 3; k++) begin
         s4_absb_in[k] = s3_b_ff[k][BW-1] ? BW'(-s3_b_ff[k]) : BW'(s3_b_ff[k]);
         // parameter numerator follows the sign change that makes b positive
         s4_ap_in[k] = s3_b_ff[k][BW-1] ? -BW'(s3_n1_ff[k]) : BW'(s3_n1_ff[k]);
         s4_tb_in[k] = TBW'(tol_ff) * TBW'(s4_absb_in[k]);
         s4_bdl_in[k] = BLW'(s4_absb_in[k]) * BLW'(s3_absd_ff[H-1:0]);
         s4_bdh_in[k] = BHW'(s4_absb_in[k]) * BHW'(s3_absd_ff[NW-1:H]);
         s4_flip_in[k] = s3_b_ff[k][BW-1] ^ s3_dneg_ff;
         s4_bnz_in[k] = (s3_b_ff[k] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (ce[3]) begin
         s4_e_ff      <= s4_e_in;
         s4_absb_ff   <= s4_absb_in;
         s4_ap_ff     <= s4_ap_in;
         s4_tb_ff     <= s4_tb_in;
         s4_bdl_ff    <= s4_bdl_in;
         s4_bdh_ff    <= s4_bdh_in;
         s4_flip_ff   <= s4_flip_in;
         s4_bnz_ff    <= s4_bnz_in;
         s4_x_ff      <= s3_x_ff;
         s4_neg_ff    <= s3_neg_ff;
         s4_absd_ff   <= s3_absd_ff;
         s4_deg_ff    <= s3_deg_ff;
         s4_inside_ff <= s3_inside_ff;
         s4_seg_ff    <= s3_seg_ff;
      end
   end

   // ------------------------------------------------------------------
   // s5: |b|*|d| summed, segment parameter window test, split tol*|b|*|d|
   // ------------------------------------------------------------------
   logic [BDW-1:0] s5_bd_in   [3];
   logic [TLW-1:0] s5_tbdl_in [3];
   logic [THW-1:0] s5_tbdh_in [3];
   logic [2:0]     s5_ptest_in;

   logic signed [EW-1:0] s5_e_ff    [3];
   logic [BDW-1:0]       s5_bd_ff   [3];
   logic [TLW-1:0]       s5_tbdl_ff [3];
   logic [THW-1:0]       s5_tbdh_ff [3];
   logic [2:0]           s5_ptest_ff;
   logic [2:0]           s5_flip_ff;
   logic [XW-1:0]        s5_x_ff    [3];
   logic [2:0]           s5_neg_ff;
   logic [NW-1:0]        s5_absd_ff;
   logic                 s5_deg_ff;
   logic                 s5_inside_ff;
   logic                 s5_seg_ff;

   always_comb begin
      logic signed [PW-1:0] lhs;
      logic signed [PW-1:0] lo;
      logic signed [PW-1:0] hi;
      for (int k = 0; k < 3; k++) begin
         s5_bd_in[k] = (BDW'(s4_bdh_ff[k]) << H) + BDW'(s4_bdl_ff[k]);
         lhs = PW'(s4_ap_ff[k]) <<< TF;
         lo  = -PW'(signed'({1'b0, s4_tb_ff[k]}));
         hi  = (PW'(signed'({1'b0, s4_absb_ff[k]})) <<< TF)
             + PW'(signed'({1'b0, s4_tb_ff[k]}));
         // parallel edge (zero denominator) fails outright
         s5_ptest_in[k] = s4_bnz_ff[k] && (lhs >= lo) && (lhs <= hi);
         s5_tbdl_in[k] = TLW'(s4_tb_ff[k]) * TLW'(s4_absd_ff[H-1:0]);
         s5_tbdh_in[k] = THW'(s4_tb_ff[k]) * THW'(s4_absd_ff[NW-1:H]);
      end
   end

   always_ff @(posedge clock) begin
      if (ce[4]) begin
         s5_e_ff      <= s4_e_ff;
         s5_bd_ff     <= s5_bd_in;
         s5_tbdl_ff   <= s5_tbdl_in;
         s5_tbdh_ff   <= s5_tbdh_in;
         s5_ptest_ff  <= s5_ptest_in;
         s5_flip_ff   <= s4_flip_ff;
         s5_x_ff      <= s4_x_ff;
         s5_neg_ff    <= s4_neg_ff;
         s5_absd_ff   <= s4_absd_ff;
         s5_deg_ff    <= s4_deg_ff;
         s5_inside_ff <= s4_inside_ff;
         s5_seg_ff    <= s4_seg_ff;
      end
   end

   // ------------------------------------------------------------------
   // s6: tol*|b|*|d| summed
   // ------------------------------------------------------------------
   logic signed [EW-1:0] s6_e_ff   [3];
   logic [BDW-1:0]       s6_bd_ff  [3];
   logic [TBDW-1:0]      s6_tbd_ff [3];
   logic [2:0]           s6_ptest_ff;
   logic [2:0]           s6_flip_ff;
   logic [XW-1:0]        s6_x_ff   [3];
   logic [2:0]           s6_neg_ff;
   logic [NW-1:0]        s6_absd_ff;
   logic                 s6_deg_ff;
   logic                 s6_inside_ff;
   logic                 s6_seg_ff;

   always_ff @(posedge clock) begin
      if (ce[5]) begin
         for (int k = 0; k < 3; k++) begin
            s6_tbd_ff[k] <= (TBDW'(s5_tbdh_ff[k]) << H) + TBDW'(s5_tbdl_ff[k]);
         end
         s6_e_ff      <= s5_e_ff;
         s6_bd_ff     <= s5_bd_ff;
         s6_ptest_ff  <= s5_ptest_ff;
         s6_flip_ff   <= s5_flip_ff;
         s6_x_ff      <= s5_x_ff;
         s6_neg_ff    <= s5_neg_ff;
         s6_absd_ff   <= s5_absd_ff;
         s6_deg_ff    <= s5_deg_ff;
         s6_inside_ff <= s5_inside_ff;
         s6_seg_ff    <= s5_seg_ff;
      end
   end

   // ------------------------------------------------------------------
   // s7: barycentric window of the meeting point, scaled by b*|d|:
   // -tol*b*|d| <= 2^14 * e <= (2^14 + tol)*b*|d|
   // the own-edge term is zero and always inside the window
   // ------------------------------------------------------------------
   logic s7_hit_in;

   logic [XW-1:0] s7_x_ff [3];
   logic [2:0]    s7_neg_ff;
   logic [NW-1:0] s7_absd_ff;
   logic          s7_deg_ff;
   logic          s7_inside_ff;
   logic          s7_hit_ff;

   always_comb begin
      logic signed [CMPW-1:0] lo;
      logic signed [CMPW-1:0] hi;
      logic signed [CMPW-1:0] ma;
      logic signed [CMPW-1:0] mb;
      logic [2:0] edge_ok;
      for (int k = 0; k < 3; k++) begin
         lo = -CMPW'(signed'({1'b0, s6_tbd_ff[k]}));
         hi = (CMPW'(signed'({1'b0, s6_bd_ff[k]})) <<< TF)
            + CMPW'(signed'({1'b0, s6_tbd_ff[k]}));
         ma = CMPW'(s6_e_ff[PR_A[k]]);
         mb = CMPW'(s6_e_ff[PR_B[k]]);
         if (s6_flip_ff[k] ^ NEG_A[k][0]) begin
            ma = -ma;
         end
         if (s6_flip_ff[k] ^ NEG_B[k][0]) begin
            mb = -mb;
         end
         ma = ma <<< TF;
         mb = mb <<< TF;
         edge_ok[k] = s6_ptest_ff[k] && (ma >= lo) && (ma <= hi)
                      && (mb >= lo) && (mb <= hi);
      end
      s7_hit_in = s6_seg_ff && !s6_deg_ff && (edge_ok != 3'b000);
   end

   always_ff @(posedge clock) begin
      if (ce[6]) begin
         s7_x_ff      <= s6_x_ff;
         s7_neg_ff    <= s6_neg_ff;
         s7_absd_ff   <= s6_absd_ff;
         s7_deg_ff    <= s6_deg_ff;
         s7_inside_ff <= s6_inside_ff;
         s7_hit_ff    <= s7_hit_in;
      end
   end

   // ------------------------------------------------------------------
   // divider: stage 0 checks for saturation (quotient >= 2^(f+3)), then
   // one restoring step per stage from quotient bit f+2 down to bit 0
   // divisor is 2|d|
   // ------------------------------------------------------------------
   div_stage_type div_in [DS];
   div_stage_type div_ff [DS];

   always_comb begin
      logic [XW+1:0] dv;
      logic [XW+1:0] rw;
      for (int k = 0; k < 3; k++) begin
         div_in[0].rem[k] = s7_x_ff[k];
         div_in[0].quo[k] = '0;
         div_in[0].sat[k] = ((XW+2)'(s7_x_ff[k])) >= ((XW+2)'(s7_absd_ff) << (F + 4));
      end
      div_in[0].neg    = s7_neg_ff;
      div_in[0].absd   = s7_absd_ff;
      div_in[0].in_tri = s7_inside_ff;
      div_in[0].hit    = s7_hit_ff;
      div_in[0].deg    = s7_deg_ff;
      for (int t = 1; t < DS; t++) begin
         div_in[t] = div_ff[t-1];
         for (int k = 0; k < 3; k++) begin
            // quotient bit f+3-t, divisor 2|d| shifted to that weight
            dv = (XW+2)'(div_ff[t-1].absd) << (F + 4 - t);
            rw = (XW+2)'(div_ff[t-1].rem[k]);
            if (rw >= dv) begin
               div_in[t].rem[k] = XW'(rw - dv);
               div_in[t].quo[k][F+3-t] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int t = 0; t < DS; t++) begin
         if (ce[7+t]) begin
            div_ff[t] <= div_in[t];
         end
      end
   end

   // ------------------------------------------------------------------
   // output register: sign, saturation and degenerate masking
   // ------------------------------------------------------------------
   logic signed [OW-1:0] bary_in [3];
   logic signed [OW-1:0] bary_ff [3];
   logic                 inside_ff;
   logic                 crosses_ff;
   logic                 deg_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (div_ff[DS-1].deg) begin
            bary_in[k] = '0;
         end else if (div_ff[DS-1].sat[k]) begin
            bary_in[k] = div_ff[DS-1].neg[k] ? {1'b1, {(OW-1){1'b0}}}
                                             : {1'b0, {(OW-1){1'b1}}};
         end else begin
            bary_in[k] = div_ff[DS-1].neg[k] ? -OW'(div_ff[DS-1].quo[k])
                                             : OW'(div_ff[DS-1].quo[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce[NST-1]) begin
         bary_ff    <= bary_in;
         inside_ff  <= div_ff[DS-1].in_tri;
         crosses_ff <= div_ff[DS-1].hit;
         deg_ff     <= div_ff[DS-1].deg;
      end
   end

   assign rsp_valid           = v_ff[NST-1];
   assign rsp_point_inside    = inside_ff;
   assign rsp_segment_crosses = crosses_ff;
   assign rsp_bary_a          = bary_ff[0];
   assign rsp_bary_b          = bary_ff[1];
   assign rsp_bary_c          = bary_ff[2];
   assign rsp_degenerate      = deg_ff;

endmodule

// ----- hw/rtl/tpst_checker.sv -----
`timescale 1ns / 1ps
// tpst_checker: port-level assertions for triangle_point_segment_test_core
// bound to the top level below; depends on tpst_pkg
module tpst_checker #(
   parameter int BARY_WIDTH = 18
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  rsp_segment_crosses,
   input logic signed [BARY_WIDTH-1:0]          rsp_bary_a,
   input logic signed [BARY_WIDTH-1:0]          rsp_bary_b,
   input logic signed [BARY_WIDTH-1:0]          rsp_bary_c,
   input logic                                  rsp_degenerate,
   input logic [tpst_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   input logic                                  csr_pready
);

   // empty output stage means nothing downstream can stall the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output stage");

   // degenerate triangle gives zero weights and no crossing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_bary_a == '0 && rsp_bary_b == '0 && rsp_bary_c == '0 && !rsp_segment_crosses)
      else $error("degenerate result carries weights or crossing");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bary_a)
         && $stable(rsp_bary_b) && $stable(rsp_bary_c) && $stable(rsp_degenerate))
      else $error("stalled result changed");

   // nothing leaves right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // tolerance read stays inside its 10 bit field
   assert property (@(posedge clock) disable iff (reset)
      csr_pready && (csr_prdata >> tpst_pkg::TOL_WIDTH) == '0)
      else $error("csr read or ready out of range");

endmodule

bind triangle_point_segment_test_core tpst_checker #(
   .BARY_WIDTH(BARY_FRAC_BITS + 4)
) u_tpst_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for triangle_point_segment_test_core
// depends on tpst_pkg and the core rtl; predicts each result from an exact model
module testbench;

   localparam int CW = 16;
   localparam int FB = 14;
   localparam int BW = FB + 4;
   localparam int LATENCY = FB + 12;
   localparam longint TONE = 64'sd16384;

   typedef struct packed {
      logic signed [CW-1:0] px, py, qx, qy;
      logic                 seg;
      logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
   } tri_item_type;

   typedef struct packed {
      logic                 in_tri;
      logic                 crosses;
      logic signed [BW-1:0] ba, bb, bc;
      logic                 degen;
   } tri_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   tri_item_type req_item = '0;

   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_point_inside, rsp_segment_crosses, rsp_degenerate;
   logic signed [BW-1:0] rsp_bary_a, rsp_bary_b, rsp_bary_c;

   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [tpst_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [tpst_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [tpst_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   tri_item_type   pending_items[$];
   tri_result_type expected_results[$];
   logic [tpst_pkg::TOL_WIDTH-1:0] tol_shadow;
   int error_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int crossing_count = 0;
   int inside_count = 0;
   bit hold_sender = 1'b0;
   int rsp_hold_cycles = 0;
   int gap_left = 0;
   int stall_left = 0;

   always #6 clock = ~clock;

   triangle_point_segment_test_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_point_x(req_item.px), .req_point_y(req_item.py),
      .req_prev_x(req_item.qx), .req_prev_y(req_item.qy),
      .req_segment_valid(req_item.seg),
      .req_vertex_a_x(req_item.ax), .req_vertex_a_y(req_item.ay),
      .req_vertex_b_x(req_item.bx), .req_vertex_b_y(req_item.by),
      .req_vertex_c_x(req_item.cx), .req_vertex_c_y(req_item.cy),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_point_inside(rsp_point_inside), .rsp_segment_crosses(rsp_segment_crosses),
      .rsp_bary_a(rsp_bary_a), .rsp_bary_b(rsp_bary_b), .rsp_bary_c(rsp_bary_c),
      .rsp_degenerate(rsp_degenerate),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // twice the signed area of (u - w) x (v - w)
   function automatic longint area2(longint ux, uy, vx, vy, wx, wy);
      return (ux - wx) * (vy - wy) - (vx - wx) * (uy - wy);
   endfunction

   // round half away from zero, then clamp to q3.14
   function automatic logic signed [BW-1:0] bary_round(longint n, longint d);
      longint un, ud, q, lim;
      un = n < 0 ? -n : n;
      ud = d < 0 ? -d : d;
      q = ((un <<< (FB + 1)) + ud) / (ud <<< 1);
      lim = 64'sd1 <<< (FB + 3);
      if ((n < 0) != (d < 0))
         return q >= lim ? BW'(-lim) : BW'(-q);
      return q >= lim ? BW'(lim - 1) : BW'(q);
   endfunction

   // does the segment meet edge line k inside the widened window
   function automatic bit edge_crossing(longint n1[3], longint n2[3], int k, longint d,
                                        longint tol);
      longint b, a, dabs;
      logic signed [127:0] m, lo, hi;
      bit flip;
      b = n1[k] - n2[k];
      a = n1[k];
      if (b == 0) return 1'b0;
      if (b < 0) begin
         a = -a;
         b = -b;
      end
      if (a * TONE < -(tol * b) || a * TONE > (TONE + tol) * b) return 1'b0;
      dabs = d < 0 ? -d : d;
      flip = ((n1[k] - n2[k]) < 0) != (d < 0);
      lo = 128'(-(tol * b)) * 128'(dabs);
      hi = 128'((TONE + tol) * b) * 128'(dabs);
      for (int j = 0; j < 3; j++) begin
         m = 128'(n1[k]) * 128'(n2[j] * TONE) - 128'(n1[j]) * 128'(n2[k] * TONE);
         if (flip) m = -m;
         if (m < lo || m > hi) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic tri_result_type predict_triangle_test(tri_item_type it,
                                                            logic [tpst_pkg::TOL_WIDTH-1:0] tol);
      tri_result_type r;
      longint c0, c1, c2, d;
      longint n1[3], n2[3];
      longint ax, ay, bx, by, cx, cy;
      bit hit;
      ax = it.ax; ay = it.ay; bx = it.bx; by = it.by; cx = it.cx; cy = it.cy;
      c0 = area2(it.px, it.py, ax, ay, bx, by);
      c1 = area2(it.px, it.py, bx, by, cx, cy);
      c2 = area2(it.px, it.py, cx, cy, ax, ay);
      r.in_tri = !((c0 < 0 || c1 < 0 || c2 < 0) && (c0 > 0 || c1 > 0 || c2 > 0));
      d = area2(bx, by, cx, cy, ax, ay);
      n1[0] = area2(bx, by, cx, cy, it.px, it.py);
      n1[1] = area2(cx, cy, ax, ay, it.px, it.py);
      n1[2] = area2(ax, ay, bx, by, it.px, it.py);
      n2[0] = area2(bx, by, cx, cy, it.qx, it.qy);
      n2[1] = area2(cx, cy, ax, ay, it.qx, it.qy);
      n2[2] = area2(ax, ay, bx, by, it.qx, it.qy);
      hit = 1'b0;
      if (d != 0 && it.seg)
         for (int k = 0; k < 3 && !hit; k++)
            hit = edge_crossing(n1, n2, k, d, longint'(tol));
      r.crosses = hit;
      r.degen = (d == 0);
      r.ba = r.degen ? '0 : bary_round(n1[0], d);
      r.bb = r.degen ? '0 : bary_round(n1[1], d);
      r.bc = r.degen ? '0 : bary_round(n1[2], d);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch at result %0d: %s got %0d expected %0d",
                  checked_count, what, got, want);
   endtask

   // append an item to the sender's pending list
   task automatic queue_pending(tri_item_type it);
      pending_items = {pending_items, it};
   endtask

   // sender: holds valid and payload until the transfer, random gaps between items
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results = {expected_results,
                                predict_triangle_test(req_item, tol_shadow)};
            sent_count++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (!hold_sender && pending_items.size() > 0) begin
               req_item <= pending_items.pop_front();
               req_valid <= 1'b1;
               // mostly no gap, some short gaps, a few long
               case ($urandom_range(0, 19))
                  0, 1, 2, 3, 4: gap_left = $urandom_range(1, 3);
                  5: gap_left = $urandom_range(10, 40);
                  default: gap_left = 0;
               endcase
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls plus a long hold-off to back up the pipeline
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3: stall_left = $urandom_range(1, 3);
            4: stall_left = $urandom_range(10, 50);
            default: stall_left = 0;
         endcase
         rsp_ready <= (stall_left == 0);
      end
   end

   // monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      tri_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, queue depth", 0, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_point_inside !== want.in_tri)
               report_mismatch("point_inside", rsp_point_inside, want.in_tri);
            if (rsp_segment_crosses !== want.crosses)
               report_mismatch("segment_crosses", rsp_segment_crosses, want.crosses);
            if (rsp_bary_a !== want.ba) report_mismatch("bary_a", rsp_bary_a, want.ba);
            if (rsp_bary_b !== want.bb) report_mismatch("bary_b", rsp_bary_b, want.bb);
            if (rsp_bary_c !== want.bc) report_mismatch("bary_c", rsp_bary_c, want.bc);
            if (rsp_degenerate !== want.degen)
               report_mismatch("degenerate", rsp_degenerate, want.degen);
            crossing_count += want.crosses;
            inside_count += want.in_tri;
         end
         checked_count++;
      end
   end

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // apb write: setup then access, pready is always high
   task automatic write_tolerance(logic [tpst_pkg::TOL_WIDTH-1:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= tpst_pkg::CSR_ADDR_WIDTH'(tpst_pkg::CSR_TOLERANCE) << 2;
      csr_pwdata <= tpst_pkg::CSR_DATA_WIDTH'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      tol_shadow = value;
      @(posedge clock);
   endtask

   function automatic logic signed [CW-1:0] rnd_coord(int span);
      if ($urandom_range(0, 15) == 0) return CW'($urandom);
      return CW'($urandom_range(0, 2 * span) - span);
   endfunction

   // random case: triangle of moderate or full-range size, sometimes degenerate, and a segment
   function automatic tri_item_type rnd_item();
      tri_item_type it;
      int span;
      span = ($urandom_range(0, 9) == 0) ? 32767 : $urandom_range(16, 2000);
      it.ax = rnd_coord(span); it.ay = rnd_coord(span);
      it.bx = rnd_coord(span); it.by = rnd_coord(span);
      case ($urandom_range(0, 9))
         0: begin // degenerate: c on line a-b
            it.cx = it.ax + (it.bx - it.ax) * 2;
            it.cy = it.ay + (it.by - it.ay) * 2;
         end
         default: begin
            it.cx = rnd_coord(span);
            it.cy = rnd_coord(span);
         end
      endcase
      it.px = rnd_coord(span); it.py = rnd_coord(span);
      case ($urandom_range(0, 5))
         0: begin // segment parallel to edge a-b
            it.qx = it.px + (it.bx - it.ax);
            it.qy = it.py + (it.by - it.ay);
         end
         1: begin // endpoint on a vertex
            it.qx = it.ax;
            it.qy = it.ay;
         end
         default: begin
            it.qx = rnd_coord(span);
            it.qy = rnd_coord(span);
         end
      endcase
      it.seg = ($urandom_range(0, 7) != 0);
      return it;
   endfunction

   function automatic tri_item_type make_item(int px, py, qx, qy, bit seg,
                                              int ax, ay, bx, by, cx, cy);
      tri_item_type it;
      it.px = CW'(px); it.py = CW'(py); it.qx = CW'(qx); it.qy = CW'(qy);
      it.seg = seg;
      it.ax = CW'(ax); it.ay = CW'(ay); it.bx = CW'(bx);
      it.by = CW'(by); it.cx = CW'(cx); it.cy = CW'(cy);
      return it;
   endfunction

   initial begin
      logic [tpst_pkg::TOL_WIDTH-1:0] tol_steps[5];
      tol_shadow = tpst_pkg::TOL_RESET;
      tol_steps = '{10'd0, 10'd1023, 10'd300, 10'd16, 10'd7};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: inside, outside, on edge, on vertex, degenerate, parallel
      queue_pending(make_item(16, 16, -50, -50, 1, 0, 0, 160, 0, 0, 160));
      queue_pending(make_item(500, 500, 600, 600, 1, 0, 0, 160, 0, 0, 160));
      queue_pending(make_item(80, 0, 80, -40, 1, 0, 0, 160, 0, 0, 160));
      queue_pending(make_item(0, 0, 10, 10, 1, 0, 0, 160, 0, 0, 160));
      queue_pending(make_item(5, 5, 300, 300, 1, 0, 0, 100, 100, 200, 200));
      queue_pending(make_item(0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
      queue_pending(make_item(-10, 20, 200, 20, 1, 0, 0, 160, 0, 0, 160));
      queue_pending(make_item(-10, 20, 200, 20, 0, 0, 0, 160, 0, 0, 160));
      queue_pending(make_item(-10, -10, 300, -10, 1, 0, 0, 160, 0, 0, 160));
      queue_pending(make_item(-32768, -32768, 32767, 32767, 1,
                              -32768, -32768, 32767, -32768, -32768, 32767));
      queue_pending(make_item(32767, 32767, -32768, -32768, 1,
                              32767, 32767, -32768, 32767, 32767, -32768));
      queue_pending(make_item(-32768, 0, 32767, 0, 1, 0, 0, 1, 0, 0, 1));
      queue_pending(make_item(20000, -20000, 0, 0, 1, 0, 0, 1, 0, 0, 1));
      queue_pending(make_item(-1, -1, -1, -1, 1, -1, -1, 0, -1, -1, 0));
      queue_pending(make_item(170, 80, 150, 80, 1, 0, 0, 160, 0, 0, 160));
      wait_drained();

      // long receiver hold-off so the pipeline fills and stalls the input
      rsp_hold_cycles = 300;
      for (int i = 0; i < 150; i++) queue_pending(rnd_item());
      wait_drained();

      foreach (tol_steps[s]) begin
         write_tolerance(tol_steps[s]);
         for (int i = 0; i < 330; i++) queue_pending(rnd_item());
         // sender pauses mid-phase until every result is back
         while (pending_items.size() > 165) @(posedge clock);
         hold_sender = 1'b1;
         while (req_valid || expected_results.size() > 0) @(posedge clock);
         hold_sender = 1'b0;
         wait_drained();
      end

      $display("covered %0d items over six tolerance settings: %0d inside, %0d crossings",
               sent_count, inside_count, crossing_count);
      $display("included degenerate and parallel cases and a long output stall");
      if (error_count == 0 && expected_results.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ----- sim.f -----
hw/rtl/tpst_pkg.sv
hw/rtl/triangle_point_segment_test_core.sv
hw/rtl/tpst_checker.sv
tb/testbench.sv
